/* rtl/core/arc_length_polyline_interpolator_top_macros.svh */
// assertion macros for the interpolator rtl
`ifndef ARC_LENGTH_POLYLINE_INTERPOLATOR_TOP_MACROS_SVH
`define ARC_LENGTH_POLYLINE_INTERPOLATOR_TOP_MACROS_SVH
// a condition that holds at every edge outside reset
`define ALPI_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// a condition that implies another in the next cycle
`define ALPI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* rtl/core/alpi_pkg.sv */
// ----------------------------------------------------------------------------
// alpi_pkg
// shared constants and types of the arc-length polyline interpolator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package alpi_pkg;
  localparam int MaxPointsDefault = 64;
  localparam int CoordW = 32;
  localparam int CumW = 40;
  localparam int SqW = 66;
  localparam int RootW = 34;
  localparam logic [CumW-1:0] CumMax = {CumW{1'b1}};
  localparam logic [16:0] OneQ16 = 17'h10000;
  localparam logic ReqLoad = 1'b0;
  localparam logic ReqQuery = 1'b1;

  // request handed to an iterative unit
  typedef struct packed {
    logic start;
  } alpi_go_t;
endpackage
`default_nettype wire

/* rtl/core/alpi_sqrt.sv */
// ----------------------------------------------------------------------------
// alpi_sqrt
// bit-serial integer square root of a 66-bit sum of squares
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module alpi_sqrt
  import alpi_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire alpi_go_t        go,
  input  wire logic [SqW-1:0]  radicand,
  output logic                 done,
  output logic [RootW-1:0]     root
);
  logic [SqW-1:0]   rem;
  logic [RootW-1:0] res;
  logic [5:0]       step;
  logic             run;
  logic [SqW+1:0]   trial;
  logic [SqW+1:0]   rem_sh;
  logic [SqW+1:0]   rad_ext;

  // radicand padded to an even width so each root bit takes one bit pair
  assign rad_ext = {2'b00, radicand};

  // two radicand bits enter per step, restoring compare
  assign rem_sh = {rem, rad_ext[SqW+1-2*step -: 2]};
  assign trial  = {{(SqW-RootW){1'b0}}, res, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go.start) begin
        run  <= 1'b1;
        step <= '0;
        rem  <= '0;
        res  <= '0;
      end else if (run) begin
        if (rem_sh >= trial) begin
          rem <= SqW'(rem_sh - trial);
          res <= {res[RootW-2:0], 1'b1};
        end else begin
          rem <= SqW'(rem_sh);
          res <= {res[RootW-2:0], 1'b0};
        end
        if (step == 6'(RootW-1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 6'd1;
      end
    end
  end
  assign root = res;
endmodule
`default_nettype wire

/* rtl/core/alpi_div.sv */
// ----------------------------------------------------------------------------
// alpi_div
// restoring divider for the segment fraction, quotient clamped to 1.0
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module alpi_div
  import alpi_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire alpi_go_t          go,
  input  wire logic [CumW+16:0]  dividend,
  input  wire logic [CumW-1:0]   divisor,
  output logic                   done,
  output logic [16:0]            quot
);
  localparam int NW = CumW + 17;
  logic [NW-1:0]  num;
  logic [CumW:0]  rem;
  logic [CumW:0]  rem_sh;
  logic [16:0]    q;
  logic           big;
  logic [5:0]     step;
  logic           run;

  assign rem_sh = {rem[CumW-1:0], num[NW-1]};

  // one quotient bit per cycle; high quotient bits only flag overflow
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go.start) begin
        run  <= 1'b1;
        num  <= dividend;
        rem  <= '0;
        q    <= '0;
        big  <= 1'b0;
        step <= '0;
      end else if (run) begin
        num <= {num[NW-2:0], 1'b0};
        if (rem_sh >= {1'b0, divisor}) begin
          rem <= rem_sh - {1'b0, divisor};
          if (q[16]) big <= 1'b1;
          q <= {q[15:0], 1'b1};
        end else begin
          rem <= rem_sh;
          if (q[16]) big <= 1'b1;
          q <= {q[15:0], 1'b0};
        end
        if (step == 6'(NW-1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 6'd1;
      end
    end
  end
  assign quot = (big || q > OneQ16) ? OneQ16 : q;
endmodule
`default_nettype wire

/* rtl/core/arc_length_polyline_interpolator_top.sv */
// ----------------------------------------------------------------------------
// arc_length_polyline_interpolator_top
// key point store with arc-length search and linear interpolation
// ----------------------------------------------------------------------------
// Usage: raise start with req_type and the payload while busy is low.
// A load (req_type 0) writes one Q16.16 point; every stored point after the
// first runs a 34-step square root for the segment length.
// A query (req_type 1) scans the cumulative distance memory one entry at a
// time (states S_QRD and S_QCHK), reads the two end points and, unless the
// segment has zero length or the target lies at its start, runs a 57-step
// divider for the fraction. Loads give no result; each query
// gives one result, shown on pos_x/pos_y/pos_z/query_error for exactly one
// cycle with result_valid high. The receiver cannot stall; the result is
// registered and busy falls the cycle after it is shown.
// Reset clears the point count, total distance and closed flag; memories
// are not cleared since only written entries are ever read.
// Throughput is set by the single-port memories, the root and the divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "arc_length_polyline_interpolator_top_macros.svh"
module arc_length_polyline_interpolator_top
  import alpi_pkg::*;
#(
  parameter int MAX_POINTS = MaxPointsDefault
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               req_type,
  input  wire logic signed [31:0] point_x,
  input  wire logic signed [31:0] point_y,
  input  wire logic signed [31:0] point_z,
  input  wire logic               last_point,
  input  wire logic signed [31:0] param_t,
  output logic                    result_valid,
  output logic signed [31:0]      pos_x,
  output logic signed [31:0]      pos_y,
  output logic signed [31:0]      pos_z,
  output logic                    query_error
);
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LRD   = 4'd1;
  localparam logic [3:0] S_LSQ   = 4'd2;
  localparam logic [3:0] S_LWR   = 4'd3;
  localparam logic [3:0] S_QRD   = 4'd4;
  localparam logic [3:0] S_QCHK  = 4'd5;
  localparam logic [3:0] S_QP0   = 4'd6;
  localparam logic [3:0] S_QP1   = 4'd7;
  localparam logic [3:0] S_QDIV  = 4'd8;
  localparam logic [3:0] S_QMUL  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;
  localparam logic [3:0] S_LSQW  = 4'd11;

  // point memory (x,y,z) and cumulative distance memory
  logic [3*CoordW-1:0] pmem [MAX_POINTS];
  logic [CumW-1:0]     cmem [MAX_POINTS];
  logic [3*CoordW-1:0] prd;
  logic [CumW-1:0]     crd;
  logic                pwe, cwe;
  logic [AW-1:0]       paddr, caddr;
  logic [3*CoordW-1:0] pwd;
  logic [CumW-1:0]     cwd;

  always_ff @(posedge clk) begin
    if (pwe) pmem[paddr] <= pwd;
    prd <= pmem[paddr];
  end
  always_ff @(posedge clk) begin
    if (cwe) cmem[caddr] <= cwd;
    crd <= cmem[caddr];
  end

  logic [3:0]          state;
  logic [CW-1:0]       count;
  logic                closed;
  logic [CumW-1:0]     total;
  logic [3*CoordW-1:0] new_pt;
  logic [3*CoordW-1:0] p0;
  logic [CumW-1:0]     cum_prev;
  logic [CumW+16:0]    target;
  logic [CW-1:0]       idx;
  logic [AW-1:0]       seg;
  logic [16:0]         alpha;
  logic [2:0]          ax;
  logic [SqW-1:0]      sq_acc;
  logic                last_q;
  logic [CumW-1:0]     cum_base;
  logic [CumW-1:0]     seg_len;
  logic signed [33:0]  dlt;
  logic [32:0]         dmag;
  logic [RootW-1:0]    root;
  logic                sq_done, dv_done;
  alpi_go_t            sq_go, dv_go;
  logic [16:0]         quot;
  logic signed [50:0]  prod;
  logic [CumW:0]       cum_sum;
  logic [16:0]         tc;
  logic [CW-1:0]       nseg;

  assign tc = param_t[31] ? 17'd0 :
              (param_t > 32'sd65536) ? OneQ16 : param_t[16:0];

  // per-axis delta of the new point against the previous one
  always_comb begin
    case (ax)
      3'd4: dlt = 34'(signed'(new_pt[95:64])) - 34'(signed'(p0[95:64]));
      3'd5: dlt = 34'(signed'(new_pt[63:32])) - 34'(signed'(p0[63:32]));
      default: dlt = 34'(signed'(new_pt[31:0])) - 34'(signed'(p0[31:0]));
    endcase
    dmag = dlt[33] ? 33'(-dlt) : dlt[32:0];
  end

  assign cum_sum = {1'b0, cum_prev} + {{(CumW+1-RootW){1'b0}}, root};
  assign nseg = CW'(count - CW'(2));

  // interpolation delta for the axis selected by ax
  logic signed [32:0] pdel;
  always_comb begin
    case (ax)
      3'd0: pdel = 33'(signed'(prd[95:64])) - 33'(signed'(p0[95:64]));
      3'd1: pdel = 33'(signed'(prd[63:32])) - 33'(signed'(p0[63:32]));
      default: pdel = 33'(signed'(prd[31:0])) - 33'(signed'(p0[31:0]));
    endcase
  end

  logic signed [31:0] pbase;
  logic signed [50:0] qfl;
  always_comb begin
    case (ax)
      3'd1: pbase = signed'(p0[95:64]);
      3'd2: pbase = signed'(p0[63:32]);
      default: pbase = signed'(p0[31:0]);
    endcase
    qfl = prod >>> 16;
  end

  always_comb begin
    pwe = 1'b0; cwe = 1'b0;
    paddr = AW'(count); caddr = AW'(idx);
    pwd = new_pt; cwd = cum_sum[CumW] ? CumMax : cum_sum[CumW-1:0];
    sq_go.start = 1'b0; dv_go.start = 1'b0;
    case (state)
      S_IDLE: ;
      S_LRD: begin
        paddr = AW'(count - CW'(1));
        caddr = AW'(count - CW'(1));
      end
      S_LWR: begin
        pwe = 1'b1; cwe = 1'b1; caddr = AW'(count);
        if (count == '0) cwd = '0;
      end
      S_QRD, S_QCHK: caddr = AW'(idx);
      S_QP0: begin paddr = seg; caddr = seg; end
      S_QP1, S_QMUL: paddr = AW'(seg + AW'(1));
      S_LSQ: sq_go.start = (ax == 3'd3);
      S_QDIV: begin
        // hold the far end point and launch the divider once
        paddr = AW'(seg + AW'(1));
        dv_go.start = (ax == 3'd6) && (seg_len != '0) && (target > {cum_base, 16'd0});
      end
      default: ;
    endcase
  end

  alpi_sqrt u_sqrt (.clk, .rst, .go(sq_go), .radicand(sq_acc), .done(sq_done), .root);
  alpi_div  u_div  (.clk, .rst, .go(dv_go), .dividend(target - {cum_base, 16'd0}),
                    .divisor(seg_len), .done(dv_done), .quot);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; count <= '0; closed <= 1'b0; total <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: if (start) begin
          if (req_type == ReqLoad) begin
            new_pt <= {point_x, point_y, point_z};
            last_q <= last_point;
            if (closed) begin
              count <= '0; total <= '0; closed <= 1'b0;
              state <= S_LWR; cum_prev <= '0;
            end else if (count >= CW'(MAX_POINTS)) begin
              if (last_point) closed <= 1'b1;
            end else if (count == '0) state <= S_LWR;
            else state <= S_LRD;
          end else if (!closed || count < CW'(2)) begin
            pos_x <= '0; pos_y <= '0; pos_z <= '0; query_error <= 1'b1;
            result_valid <= 1'b1; state <= S_OUT;
          end else begin
            target <= (CumW+17)'(tc * total);
            idx <= CW'(1); seg <= AW'(nseg); state <= S_QRD;
          end
        end
        S_LRD: begin ax <= 3'd0; sq_acc <= '0; state <= S_LSQ; end
        S_LSQ: begin
          if (ax == 3'd0) begin p0 <= prd; cum_prev <= crd; end
          if (ax == 3'd0) ax <= 3'd4;
          else if (ax == 3'd3) state <= S_LSQW;
          else begin
            sq_acc <= sq_acc + SqW'(dmag * dmag);
            ax <= (ax == 3'd6) ? 3'd3 : ((ax == 3'd4) ? 3'd5 : 3'd6);
          end
        end
        S_LSQW: if (sq_done) state <= S_LWR;
        S_LWR: begin
          count <= count + CW'(1);
          total <= (count == '0) ? '0 : cwd;
          if (last_q) closed <= 1'b1;
          state <= S_IDLE;
        end
        S_QRD: state <= S_QCHK;
        S_QCHK: begin
          if ({crd, 16'd0} > target) begin
            seg <= AW'(idx - CW'(1)); state <= S_QP0;
          end else if (idx == CW'(count - CW'(1))) state <= S_QP0;
          else begin idx <= idx + CW'(1); state <= S_QRD; end
        end
        S_QP0: state <= S_QP1;
        S_QP1: begin p0 <= prd; cum_base <= crd; ax <= 3'd7; state <= S_QDIV; end
        S_QDIV: begin
          if (ax == 3'd7) begin
            seg_len <= crd - cum_base; ax <= 3'd6;
          end else if (ax == 3'd6) begin
            if (seg_len == '0 || target <= {cum_base, 16'd0}) begin
              alpha <= '0; ax <= 3'd0; state <= S_QMUL;
            end else ax <= 3'd0;
          end else if (dv_done) begin
            alpha <= quot; ax <= 3'd0; state <= S_QMUL;
          end
        end
        S_QMUL: begin
          // product of one axis registered, then floored shift and add
          prod <= pdel * signed'({1'b0, alpha});
          if (ax != 3'd0) begin
            case (ax)
              3'd1: pos_x <= 32'(pbase + 32'(qfl));
              3'd2: pos_y <= 32'(pbase + 32'(qfl));
              default: pos_z <= 32'(pbase + 32'(qfl));
            endcase
          end
          if (ax == 3'd3) begin
            query_error <= 1'b0; result_valid <= 1'b1; state <= S_OUT;
          end
          ax <= ax + 3'd1;
        end
        S_OUT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

  `ALPI_ASSERT_ALWAYS(a_count_range, clk, rst, count <= CW'(MAX_POINTS), "count overflow")
  `ALPI_ASSERT_NEXT(a_result_once, clk, rst, result_valid, !result_valid, "double result")
  `ALPI_ASSERT_NEXT(a_busy_after_start, clk, rst, start && !busy && req_type == ReqQuery,
    busy, "query not taken")
  `ALPI_ASSERT_ALWAYS(a_err_zero, clk, rst, !(result_valid && query_error) || pos_x == '0,
    "error result not zero")
endmodule
`default_nettype wire

/* test/tb_arc_length_polyline_interpolator_top.sv */
// ----------------------------------------------------------------------------
// tb_arc_length_polyline_interpolator_top
// self-checking bench for the arc-length polyline interpolator
// ----------------------------------------------------------------------------
// Loads key point sets and queries positions along them. A directed table
// covers the error cases, the clamp of t, degenerate segments and extreme
// coordinates. A full store and random sets with random queries follow. Every
// query result is checked field by field against a behavioral model of the
// point store, the square root, the segment search and the interpolation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_arc_length_polyline_interpolator_top;
  import alpi_pkg::*;

  localparam int NPts = MaxPointsDefault;

  typedef struct {
    logic               kind;
    logic signed [31:0] x, y, z;
    logic               last;
    logic signed [31:0] t;
  } req_t;

  typedef struct {
    logic signed [31:0] x, y, z;
    logic               err;
  } pos_t;

  // table row: request plus an optional typed-in expectation
  typedef struct {
    req_t r;
    logic fixed;
    pos_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic req_type = ReqLoad;
  logic signed [31:0] point_x = '0, point_y = '0, point_z = '0, param_t = '0;
  logic last_point = 1'b0;
  logic busy, result_valid, query_error;
  logic signed [31:0] pos_x, pos_y, pos_z;

  arc_length_polyline_interpolator_top i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req_type(req_type),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .last_point(last_point), .param_t(param_t), .result_valid(result_valid),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .query_error(query_error)
  );

  always #4 clk = ~clk;

  // model state
  logic signed [31:0] pt_x [NPts], pt_y [NPts], pt_z [NPts];
  logic [CumW-1:0] cum_at [NPts];
  int unsigned n_pts;
  logic closed;
  logic [CumW-1:0] total;

  pos_t expected_pos [$];
  int mismatches = 0;
  int unexpected = 0;

  // floor square root of a 66-bit sum of squares
  function automatic logic [RootW-1:0] isqrt(logic [SqW-1:0] s);
    logic [RootW-1:0] r;
    logic [RootW-1:0] c;
    logic [2*RootW-1:0] sq;
    r = '0;
    for (int b = RootW - 1; b >= 0; b--) begin
      c = r | (34'd1 << b);
      sq = c * c;
      if (sq <= s) r = c;
    end
    return r;
  endfunction

  function automatic logic [SqW-1:0] sq_delta(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [33:0] d;
    logic [33:0] m;
    d = 34'(b) - 34'(a);
    m = d < 0 ? 34'(-d) : 34'(d);
    return SqW'(m) * SqW'(m);
  endfunction

  function automatic logic signed [31:0] lerp(logic signed [31:0] a, logic signed [31:0] b,
                                             logic [16:0] alpha);
    longint d, prod, q;
    d = longint'(b) - longint'(a);
    prod = d * longint'(alpha);
    if (prod >= 0) q = prod >>> 16;
    else q = -((-prod + 65535) >>> 16);
    return 32'(longint'(a) + q);
  endfunction

  // field-by-field comparison of two positions
  function automatic logic same_pos(pos_t a, pos_t b);
    return a.x === b.x && a.y === b.y && a.z === b.z && a.err === b.err;
  endfunction

  // apply one accepted request to the model, queue any result
  task automatic predict_position(req_t r);
    logic [SqW-1:0] s;
    logic [CumW:0] c;
    longint tc;
    logic [63:0] target, len, base, al;
    int unsigned seg, k;
    pos_t p;
    if (r.kind == ReqLoad) begin
      if (closed) begin
        n_pts = 0; total = '0; closed = 1'b0;
      end
      if (n_pts < NPts) begin
        k = n_pts;
        pt_x[k] = r.x; pt_y[k] = r.y; pt_z[k] = r.z;
        c = '0;
        if (k > 0) begin
          s = sq_delta(pt_x[k-1], r.x) + sq_delta(pt_y[k-1], r.y)
            + sq_delta(pt_z[k-1], r.z);
          c = 41'(cum_at[k-1]) + 41'(isqrt(s));
          if (c > 41'(CumMax)) c = 41'(CumMax);
        end
        cum_at[k] = c[CumW-1:0];
        total = c[CumW-1:0];
        n_pts = k + 1;
      end
      if (r.last) closed = 1'b1;
      return;
    end
    p = '{x: '0, y: '0, z: '0, err: 1'b1};
    if (closed && n_pts >= 2) begin
      tc = r.t < 0 ? 0 : (r.t > 65536 ? 65536 : longint'(r.t));
      target = 64'(tc) * 64'(total);
      seg = n_pts - 2;
      for (int i = 0; i + 1 < n_pts; i++)
        if ((64'(cum_at[i+1]) << 16) > target) begin
          seg = i;
          break;
        end
      len = 64'(cum_at[seg+1]) - 64'(cum_at[seg]);
      base = 64'(cum_at[seg]) << 16;
      al = 0;
      if (len != 0 && target > base) begin
        al = (target - base) / len;
        if (al > 65536) al = 65536;
      end
      p.x = lerp(pt_x[seg], pt_x[seg+1], 17'(al));
      p.y = lerp(pt_y[seg], pt_y[seg+1], 17'(al));
      p.z = lerp(pt_z[seg], pt_z[seg+1], 17'(al));
      p.err = 1'b0;
    end
    expected_pos.push_back(p);
  endtask

  // compare each strobed result with the oldest expectation
  always @(posedge clk) begin
    pos_t w;
    if (!rst && result_valid) begin
      if (expected_pos.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= 10)
          $display("unexpected result x=%h y=%h z=%h err=%b", pos_x, pos_y, pos_z,
                   query_error);
      end else begin
        w = expected_pos.pop_front();
        if (pos_x !== w.x || pos_y !== w.y || pos_z !== w.z || query_error !== w.err) begin
          mismatches++;
          if (mismatches + unexpected <= 10)
            $display("mismatch: exp x=%h y=%h z=%h err=%b got x=%h y=%h z=%h err=%b",
                     w.x, w.y, w.z, w.err, pos_x, pos_y, pos_z, query_error);
        end
      end
    end
  end

  int gap_left = 0;

  // hand one request to the block, with bursts and gaps
  task automatic send_request(req_t r);
    if (gap_left > 0) begin
      start <= 1'b0;
      repeat (gap_left) @(posedge clk);
      gap_left = 0;
    end
    start <= 1'b1;
    req_type <= r.kind;
    point_x <= r.x; point_y <= r.y; point_z <= r.z;
    last_point <= r.last; param_t <= r.t;
    do @(posedge clk); while (busy);
    predict_position(r);
    if ($urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 12);
    if (gap_left > 0) start <= 1'b0;
  endtask

  function automatic req_t ld(logic signed [31:0] x, logic signed [31:0] y,
                              logic signed [31:0] z, logic last);
    return '{kind: ReqLoad, x: x, y: y, z: z, last: last, t: 32'($urandom)};
  endfunction

  function automatic req_t qry(logic signed [31:0] t);
    return '{kind: ReqQuery, x: 32'($urandom), y: 32'($urandom), z: 32'($urandom),
             last: 1'($urandom), t: t};
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return 32'($urandom);
      1: return 32'sh8000_0000 + 32'($urandom_range(0, 3));
      2: return 32'sh7fff_fffc + 32'($urandom_range(0, 3));
      default: return 32'($signed(20'($urandom)));
    endcase
  endfunction

  function automatic logic signed [31:0] rand_t();
    case ($urandom_range(0, 5))
      0: return 32'($urandom);
      1: return 32'sd65536 + 32'($urandom_range(0, 2));
      2: return -32'sd1;
      default: return 32'($urandom_range(0, 65536));
    endcase
  endfunction

  row_t plan [$];
  pos_t err_pos;
  pos_t none;

  initial begin
    int n;
    err_pos = '{x: '0, y: '0, z: '0, err: 1'b1};
    none = '{x: '0, y: '0, z: '0, err: 1'b0};
    n_pts = 0; closed = 1'b0; total = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: error cases, clamp, zero-length, extremes
    plan.push_back('{qry(32'sd30000), 1'b1, err_pos});
    plan.push_back('{ld(32'sh0001_0000, 0, 0, 1'b0), 1'b0, none});
    plan.push_back('{qry(32'sd0), 1'b1, err_pos});
    plan.push_back('{ld(32'sh0001_0000, 0, 0, 1'b1), 1'b0, none});
    plan.push_back('{qry(32'sd32768), 1'b1, '{32'sh0001_0000, 0, 0, 1'b0}});
    plan.push_back('{ld(32'sh0003_0000, 0, 0, 1'b1), 1'b1, none});
    plan.push_back('{qry(32'sd1), 1'b1, err_pos});
    plan.push_back('{ld(0, 0, 0, 1'b0), 1'b0, none});
    plan.push_back('{ld(32'sh0004_0000, 0, 0, 1'b0), 1'b0, none});
    plan.push_back('{ld(32'sh0004_0000, 32'sh0003_0000, 0, 1'b1), 1'b0, none});
    plan.push_back('{qry(-32'sd5), 1'b1, '{0, 0, 0, 1'b0}});
    plan.push_back('{qry(32'sd65536), 1'b1, '{32'sh0004_0000, 32'sh0003_0000, 0, 1'b0}});
    plan.push_back('{qry(32'sh7fff_ffff), 1'b1,
                     '{32'sh0004_0000, 32'sh0003_0000, 0, 1'b0}});
    plan.push_back('{qry(32'sd32768), 1'b0, none});
    plan.push_back('{ld(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0), 1'b0, none});
    plan.push_back('{ld(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0), 1'b0, none});
    plan.push_back('{ld(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 1'b1), 1'b0, none});
    plan.push_back('{qry(32'sd20000), 1'b0, none});
    plan.push_back('{qry(32'sd50000), 1'b0, none});
    plan.push_back('{qry(32'sd65535), 1'b0, none});
    foreach (plan[i]) begin
      send_request(plan[i].r);
      // typed-in query rows must agree with the predictor
      if (plan[i].fixed && plan[i].r.kind == ReqQuery &&
          !same_pos(expected_pos[$], plan[i].want)) begin
        mismatches++;
        $display("table row %0d disagrees with prediction", i);
      end
    end

    // full store: 66 points, the overflow ones dropped, then queries
    for (int i = 0; i < NPts + 2; i++)
      send_request(ld(rand_coord(), rand_coord(), rand_coord(), i == NPts + 1));
    repeat (6) send_request(qry(rand_t()));

    // random sets with repeated queries, plus some noise
    n = 0;
    while (n < 1700) begin
      int len;
      len = $urandom_range(0, 9) == 0 ? $urandom_range(1, 70) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        logic shortz;
        req_t r;
        shortz = $urandom_range(0, 7) == 0;
        r = ld(rand_coord(), rand_coord(), rand_coord(), i == len - 1);
        if (shortz && i > 0) begin
          r.x = pt_x[(n_pts - 1) % NPts]; r.y = pt_y[(n_pts - 1) % NPts];
          r.z = pt_z[(n_pts - 1) % NPts];
        end
        if ($urandom_range(0, 15) == 0) r.last = ~r.last;
        send_request(r);
        n++;
        if ($urandom_range(0, 19) == 0) begin
          send_request(qry(rand_t()));
          n++;
        end
      end
      repeat ($urandom_range(1, 6)) begin
        send_request(qry(rand_t()));
        n++;
      end
    end
    start <= 1'b0;

    // drain
    fork
      begin
        wait (expected_pos.size() == 0);
        repeat (200) @(posedge clk);
      end
      begin
        repeat (100000) @(posedge clk);
      end
    join_any
    if (mismatches == 0 && unexpected == 0 && expected_pos.size() == 0)
      $display("arc_length_polyline_interpolator_top test passed");
    else
      $display("arc_length_polyline_interpolator_top test failed");
    $finish;
  end

  // overall limit
  initial begin
    #40ms;
    $display("arc_length_polyline_interpolator_top test failed");
    $finish;
  end
endmodule
